// File: rtl/odpq_pkg.sv
package odpq_pkg;

  // Default palette depth
  localparam int PALETTE_SIZE_DEF = 16;

  // Register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_SCALE  = 2'd1;

  localparam logic [4:0]  PALETTE_COUNT_RST = 5'd16;
  localparam logic [11:0] DITHER_SCALE_RST  = 12'd64;

  // Input opcodes
  localparam logic OP_WRITE_ENTRY = 1'b0;
  localparam logic OP_QUANTIZE    = 1'b1;

  // Squared distance: 3*255*255 fits in 18 bits
  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Palette write request
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [23:0] color;
  } pal_wr_t;

  // Search request: start strobe, raw entry count and dithered color
  typedef struct packed {
    logic       start;
    logic [4:0] count;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } srch_req_t;

  // Search response: done strobe and winning color
  typedef struct packed {
    logic        done;
    logic [23:0] color;
  } srch_rsp_t;

  // 4x4 Bayer weight in eighths, index {row, col}
  function automatic logic signed [4:0] bayer_weight(input logic [3:0] idx);
    logic signed [4:0] w;
    unique case (idx)
      4'd0:  w = -5'sd7;
      4'd1:  w =  5'sd1;
      4'd2:  w = -5'sd5;
      4'd3:  w =  5'sd3;
      4'd4:  w =  5'sd5;
      4'd5:  w = -5'sd3;
      4'd6:  w =  5'sd7;
      4'd7:  w = -5'sd1;
      4'd8:  w = -5'sd4;
      4'd9:  w =  5'sd4;
      4'd10: w = -5'sd6;
      4'd11: w =  5'sd2;
      4'd12: w =  5'sd8;
      4'd13: w =  5'sd0;
      4'd14: w =  5'sd6;
      4'd15: w = -5'sd2;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/odpq_nearest.sv
module odpq_nearest #(
  parameter int PALETTE_SIZE = odpq_pkg::PALETTE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  odpq_pkg::pal_wr_t   wr,
  input  odpq_pkg::srch_req_t req,
  output odpq_pkg::srch_rsp_t rsp
);

  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int DW    = odpq_pkg::DIST_W;

  // Palette memory, per-entry valid bits give the zero reset value
  logic [23:0]       mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] vld_r;

  logic [IDX_W-1:0] wr_addr;
  logic             wr_ok;

  assign wr_addr = IDX_W'(wr.idx);
  assign wr_ok   = wr.en && (int'(wr.idx) < PALETTE_SIZE);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read sequencer: walks entries 0..lim, at least entry 0
  logic             issue_r;
  logic [IDX_W-1:0] addr_r;
  logic [IDX_W-1:0] lim_r;
  logic             en_r;
  logic [IDX_W-1:0] lim_nxt;

  always_comb begin
    if (req.count == 5'd0) begin
      lim_nxt = '0;
    end else if (int'(req.count) >= PALETTE_SIZE) begin
      lim_nxt = IDX_W'(PALETTE_SIZE - 1);
    end else begin
      lim_nxt = IDX_W'(req.count - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      addr_r  <= '0;
    end else if (req.start) begin
      issue_r <= 1'b1;
      addr_r  <= '0;
    end else if (issue_r) begin
      addr_r <= IDX_W'(addr_r + 1'b1);
      if (addr_r == lim_r) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      lim_r <= lim_nxt;
      en_r  <= (req.count != 5'd0);
    end
  end

  // Stage 1: registered memory read
  logic        s1_vld_r, s1_first_r, s1_last_r;
  logic [23:0] s1_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_color_r <= vld_r[addr_r] ? mem[addr_r] : 24'd0;
    s1_first_r <= (addr_r == '0);
    s1_last_r  <= (addr_r == lim_r);
  end

  // Stage 2: squared RGB distance
  logic        s2_vld_r, s2_first_r, s2_last_r;
  logic [23:0] s2_color_r;
  logic [DW-1:0] s2_dist_r;

  function automatic logic [15:0] sq_abs(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] m;
    m = (a >= b) ? (a - b) : (b - a);
    return m * m;
  endfunction

  logic [DW-1:0] ent_dist;
  assign ent_dist = DW'(sq_abs(s1_color_r[23:16], req.r))
                  + DW'(sq_abs(s1_color_r[15:8],  req.g))
                  + DW'(sq_abs(s1_color_r[7:0],   req.b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_dist_r  <= ent_dist;
    s2_color_r <= s1_color_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // Stage 3: running minimum, strictly-below wins; entry 0 is the fallback
  logic [DW-1:0] best_dist_r;
  logic [23:0]   best_color_r;
  logic          done_r;
  logic [DW-1:0] cur_best;
  logic          win;

  assign cur_best = s2_first_r ? odpq_pkg::MAX_DIST : best_dist_r;
  assign win      = en_r && (s2_dist_r < cur_best);

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      best_dist_r <= win ? s2_dist_r : cur_best;
      if (win || s2_first_r) begin
        best_color_r <= s2_color_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= s2_vld_r && s2_last_r;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.color = best_color_r;

endmodule

// File: rtl/ordered_dither_palette_quantizer_unit.sv
// Ordered-dither palette quantizer, 4x4 Bayer matrix.
// Input channel (in_valid/in_ready): op 0 writes one palette entry and
// gives no result; op 1 dithers one RGBA pixel and returns the nearest
// palette color with alpha 0xFF on the output channel (out_valid/out_ready).
// A zero pixel returns zero. Config channel (cfg_valid/cfg_ready, always
// ready): index 0 palette_count, index 1 dither_scale; write only when idle.
// Sequence: a palette write leaves the input ready. A pixel is accepted,
// passes the dither offset and clamp states, then the search walks
// max(N,1) entries through one shared read/distance/compare pipeline,
// one entry per cycle, N = min(palette_count, PALETTE_SIZE); a zero pixel
// skips straight to the result. in_ready returns in the same cycle that
// the result moves into the output register. The output register lets a
// new item in while a result waits; if the receiver stalls, a second
// result holds in the block until the register frees. Reset clears the
// palette to zero, palette_count to 16 and dither_scale to 64.
module ordered_dither_palette_quantizer_unit #(
  parameter int PALETTE_SIZE = odpq_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [31:0]                     in_pixel_in,
  input  logic [1:0]                      in_row_phase,
  input  logic [1:0]                      in_col_phase,
  input  logic [3:0]                      in_entry_index,
  input  logic [23:0]                     in_entry_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_pixel_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odpq_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DITHER = 5'b00010,
    ST_CLAMP  = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [4:0]  palette_count_r;
  logic [11:0] dither_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r <= odpq_pkg::PALETTE_COUNT_RST;
      dither_scale_r  <= odpq_pkg::DITHER_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        odpq_pkg::CFG_PALETTE_COUNT: palette_count_r <= cfg_data[4:0];
        odpq_pkg::CFG_DITHER_SCALE:  dither_scale_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic in_xfer, out_xfer, out_free;
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign out_free = !out_valid || out_ready;

  // Pixel operands
  logic [23:0]       rgb_in_r;
  logic signed [4:0] k_r;
  logic signed [8:0] d_r;
  logic [7:0]        r_r, g_r, b_r;
  logic [31:0]       res_r;

  // Dither offset: trunc toward zero of scale*k/128 via magnitude
  logic [3:0]  k_mag;
  logic [15:0] k_prod;
  logic [7:0]  d_mag;
  assign k_mag  = k_r[4] ? 4'(-k_r) : k_r[3:0];
  assign k_prod = dither_scale_r * k_mag;
  assign d_mag  = k_prod[14:7];

  function automatic logic [7:0] add_clamp(input logic [7:0] ch, input logic signed [8:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, ch}) + 10'(d);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  // Search engine
  odpq_pkg::pal_wr_t   wr;
  odpq_pkg::srch_req_t req;
  odpq_pkg::srch_rsp_t rsp;

  assign wr.en    = in_xfer && (in_op == odpq_pkg::OP_WRITE_ENTRY);
  assign wr.idx   = in_entry_index;
  assign wr.color = in_entry_color;

  assign req.start = (state_r == ST_CLAMP);
  assign req.count = palette_count_r;
  assign req.r     = r_r;
  assign req.g     = g_r;
  assign req.b     = b_r;

  odpq_nearest #(.PALETTE_SIZE(PALETTE_SIZE)) u_nearest (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .req   (req),
    .rsp   (rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_op == odpq_pkg::OP_QUANTIZE)) begin
          state_nxt = (in_pixel_in == 32'd0) ? ST_HOLD : ST_DITHER;
        end
      end
      ST_DITHER: state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (rsp.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rgb_in_r <= in_pixel_in[31:8];
      k_r      <= odpq_pkg::bayer_weight({in_row_phase, in_col_phase});
      res_r    <= 32'd0;
    end
    if (state_r == ST_DITHER) begin
      d_r <= k_r[4] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
    end
    if (state_r == ST_CLAMP) begin
      r_r <= add_clamp(rgb_in_r[23:16], d_r);
      g_r <= add_clamp(rgb_in_r[15:8],  d_r);
      b_r <= add_clamp(rgb_in_r[7:0],   d_r);
    end
    if ((state_r == ST_SEARCH) && rsp.done) begin
      res_r <= {rsp.color, odpq_pkg::ALPHA_OPAQUE};
    end
  end

  // Output register
  logic        out_valid_r;
  logic [31:0] out_pixel_r;
  logic        out_load;
  assign out_load = (state_r == ST_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= res_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

// File: rtl/odpq_checker.sv
module odpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_out
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out))
    else $error("result changed while stalled");

  // Every result is zero or opaque
  a_out_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_out == 32'd0) || (out_pixel_out[7:0] == 8'hFF))
    else $error("result neither zero nor opaque");

  // A pixel transfer blocks the input for the next cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == odpq_pkg::OP_QUANTIZE) |=> !in_ready)
    else $error("input ready right after a pixel transfer");

  // A palette write keeps the input ready into the next cycle
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == odpq_pkg::OP_WRITE_ENTRY) |=> in_ready)
    else $error("input not ready after a palette write");

endmodule

bind ordered_dither_palette_quantizer_unit odpq_checker u_odpq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_out (out_pixel_out)
);

// File: tb/odpq_result_checker.sv
module odpq_result_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic                            in_op,
  input  wire logic [31:0]                     in_pixel_in,
  input  wire logic [1:0]                      in_row_phase,
  input  wire logic [1:0]                      in_col_phase,
  input  wire logic [3:0]                      in_entry_index,
  input  wire logic [23:0]                     in_entry_color,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [31:0]                     out_pixel_out,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [odpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [odpq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                          fail_count,
  output int unsigned                          pending_count,
  output int unsigned                          compared_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // Bayer weights in eighths, indexed by {row, col}
  localparam int BAYER_EIGHTHS [16] = '{-7,  1, -5,  3,
                                         5, -3,  7, -1,
                                        -4,  4, -6,  2,
                                         8,  0,  6, -2};
  localparam int WORST_DIST = 3 * 255 * 255;
  localparam int MIRROR_SIZE = odpq_pkg::PALETTE_SIZE_DEF;

  logic [23:0] palette_mirror [MIRROR_SIZE];
  logic [4:0]  count_mirror;
  logic [11:0] scale_mirror;
  logic [31:0] expected_pixels [$];
  int unsigned mismatches;
  int unsigned compared;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int clamp_channel(input int v);
    if (v > 255) return 255;
    if (v < 0) return 0;
    return v;
  endfunction

  // Dither one pixel and pick the nearest palette entry
  function automatic logic [31:0] dither_quantize(input logic [31:0] px,
                                                   input logic [1:0] row,
                                                   input logic [1:0] col);
    int weight, prod, offs, r, g, b, span, best, best_dist, cand_dist, i;
    logic [23:0] e;
    if (px == 32'd0) return 32'd0;
    weight = BAYER_EIGHTHS[{row, col}];
    prod = int'(scale_mirror) * weight;
    // offset truncates toward zero
    offs = (prod < 0) ? -((-prod) / 128) : prod / 128;
    r = clamp_channel(int'(px[31:24]) + offs);
    g = clamp_channel(int'(px[23:16]) + offs);
    b = clamp_channel(int'(px[15:8]) + offs);
    span = (int'(count_mirror) > MIRROR_SIZE) ? MIRROR_SIZE : int'(count_mirror);
    best = 0;
    best_dist = WORST_DIST;
    for (i = 0; i < span; i++) begin
      e = palette_mirror[i];
      cand_dist = (int'(e[23:16]) - r) * (int'(e[23:16]) - r)
                + (int'(e[15:8]) - g) * (int'(e[15:8]) - g)
                + (int'(e[7:0]) - b) * (int'(e[7:0]) - b);
      // strict compare: earliest of equal distances keeps the win
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = i;
      end
    end
    return {palette_mirror[best], odpq_pkg::ALPHA_OPAQUE};
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      foreach (palette_mirror[i]) palette_mirror[i] = 24'd0;
      count_mirror = odpq_pkg::PALETTE_COUNT_RST;
      scale_mirror = odpq_pkg::DITHER_SCALE_RST;
      expected_pixels.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          odpq_pkg::CFG_PALETTE_COUNT: count_mirror = cfg_data[4:0];
          odpq_pkg::CFG_DITHER_SCALE:  scale_mirror = cfg_data[11:0];
          default: ;
        endcase
      end
      // result side first: a result at this edge belongs to an older pixel
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %08h with nothing expected", out_pixel_out));
        end else begin
          want = expected_pixels.pop_front();
          compared++;
          if (out_pixel_out !== want)
            report_mismatch($sformatf("pixel_out %08h, expected %08h", out_pixel_out, want));
        end
      end
      // input side: palette writes update the mirror, pixels queue a prediction
      if (in_valid && in_ready) begin
        if (in_op == odpq_pkg::OP_WRITE_ENTRY) begin
          palette_mirror[in_entry_index] = in_entry_color;
        end else begin
          expected_pixels.push_back(dither_quantize(in_pixel_in, in_row_phase, in_col_phase));
        end
      end
    end
    fail_count     <= mismatches;
    pending_count  <= expected_pixels.size();
    compared_count <= compared;
  end

endmodule

// File: tb/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 32;
  localparam int STALL_LIMIT     = 2000;
  localparam int LONG_HOLD       = 300;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 54;

  localparam logic [23:0] SWATCHES [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                           24'h0000FF, 24'h808080, 24'h7F7F7F, 24'h123456};

  typedef struct packed {
    logic        op;
    logic [31:0] pixel;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [3:0]  idx;
    logic [23:0] color;
  } px_item_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_op = odpq_pkg::OP_WRITE_ENTRY;
  logic [31:0]                     in_pixel_in = '0;
  logic [1:0]                      in_row_phase = '0;
  logic [1:0]                      in_col_phase = '0;
  logic [3:0]                      in_entry_index = '0;
  logic [23:0]                     in_entry_color = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [31:0]                     out_pixel_out;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [odpq_pkg::CFG_IDX_W-1:0]  cfg_index = odpq_pkg::CFG_PALETTE_COUNT;
  logic [odpq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count, pending_count, compared_count;

  // traffic shaping shared between the stimulus and the receiver
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_asks = 0;

  int unsigned palette_writes = 0;
  int unsigned pixels_sent = 0;
  int unsigned zero_pixels = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;

  ordered_dither_palette_quantizer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_pixel_in    (in_pixel_in),
    .in_row_phase   (in_row_phase),
    .in_col_phase   (in_col_phase),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  odpq_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_pixel_in    (in_pixel_in),
    .in_row_phase   (in_row_phase),
    .in_col_phase   (in_col_phase),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_count);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall per result, one long hold on request
  initial begin
    int stall;
    int hold_served;
    hold_served = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (hold_served < hold_asks) begin
        stall = LONG_HOLD;
        hold_served++;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic px_item_t pixel_item(input logic [31:0] px, input logic [1:0] row,
                                          input logic [1:0] col);
    px_item_t it;
    it = '0;
    it.op = odpq_pkg::OP_QUANTIZE;
    it.pixel = px;
    it.row = row;
    it.col = col;
    return it;
  endfunction

  function automatic px_item_t entry_item(input logic [3:0] idx, input logic [23:0] color);
    px_item_t it;
    it = '0;
    it.op = odpq_pkg::OP_WRITE_ENTRY;
    it.idx = idx;
    it.color = color;
    return it;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mix of palette writes and pixels; swatches make ties and exact hits common
  function automatic px_item_t random_item();
    px_item_t it;
    int pick;
    it.row = 2'($urandom);
    it.col = 2'($urandom);
    it.idx = 4'($urandom);
    it.color = 24'($urandom);
    it.pixel = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.op = odpq_pkg::OP_WRITE_ENTRY;
      if ($urandom_range(0, 1) == 1) it.color = SWATCHES[$urandom_range(0, 7)];
    end else begin
      it.op = odpq_pkg::OP_QUANTIZE;
      if (pick < 23) it.pixel = 32'd0;
      else if (pick < 45) it.pixel = {SWATCHES[$urandom_range(0, 7)], 8'($urandom)};
      else if (pick < 70) it.pixel = {rand_channel(), rand_channel(), rand_channel(),
                                      8'($urandom)};
    end
    return it;
  endfunction

  // One input transfer; valid stays up when the next item follows with no gap
  task automatic send_item(input px_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_pixel_in    <= it.pixel;
    in_row_phase   <= it.row;
    in_col_phase   <= it.col;
    in_entry_index <= it.idx;
    in_entry_color <= it.color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == odpq_pkg::OP_WRITE_ENTRY) begin
      palette_writes++;
    end else begin
      pixels_sent++;
      if (it.pixel == 32'd0) zero_pixels++;
    end
  endtask

  // Stop offering, wait for every result, then let in-flight work finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [4:0] count, input logic [11:0] scale);
    cfg_valid <= 1'b1;
    cfg_index <= odpq_pkg::CFG_PALETTE_COUNT;
    cfg_data  <= odpq_pkg::CFG_DATA_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= odpq_pkg::CFG_DITHER_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  initial begin
    int p, n;
    logic [4:0]  count;
    logic [11:0] scale;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, all-zero palette, then corners and ties
    send_item(pixel_item(32'h0000_0000, 2'd0, 2'd0));
    send_item(pixel_item(32'h0000_00FF, 2'd1, 2'd2));
    send_item(entry_item(4'd0, 24'hFFFFFF));
    send_item(entry_item(4'd15, 24'h00FF00));
    send_item(entry_item(4'd5, 24'h123456));
    send_item(entry_item(4'd6, 24'h123456));
    send_item(entry_item(4'd3, 24'hFF0000));
    send_item(pixel_item(32'hFFFF_FF00, 2'd3, 2'd0));
    send_item(pixel_item(32'h0000_0001, 2'd0, 2'd0));
    send_item(pixel_item(32'h1234_5677, 2'd3, 2'd1));
    send_item(pixel_item(32'h00FF_0080, 2'd2, 2'd1));
    send_item(pixel_item(32'hF008_0011, 2'd1, 2'd3));

    // empty search: entry zero comes out
    wait_idle();
    write_regs(5'd0, 12'd4095);
    send_item(pixel_item(32'h5A3C_1E0F, 2'd2, 2'd2));
    send_item(pixel_item(32'h0000_0000, 2'd1, 2'd1));

    // single entry, no dither; a distance equal to the worst case never wins
    wait_idle();
    write_regs(5'd1, 12'd0);
    send_item(pixel_item(32'h0000_00FF, 2'd0, 2'd0));
    send_item(entry_item(4'd0, 24'h000000));
    send_item(pixel_item(32'hFFFF_FF01, 2'd0, 2'd1));

    // count beyond the store, full scale: clamp and truncation toward zero
    wait_idle();
    write_regs(5'd31, 12'd4095);
    send_item(pixel_item(32'h8080_8080, 2'd3, 2'd0));
    send_item(pixel_item(32'h8080_8080, 2'd0, 2'd0));
    send_item(pixel_item(32'h4020_FF33, 2'd1, 2'd3));

    // Random phases over several register settings
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      case (p)
        0: begin count = 5'd16; scale = 12'd4095; tx_idle = 1'b0; rx_idle = 1'b0; end
        1: begin count = 5'd0;  scale = 12'($urandom); end
        2: begin count = 5'd1;  scale = 12'd0; end
        3: begin count = 5'd31; scale = 12'($urandom); end
        4: begin count = 5'd17; scale = 12'd2048; rx_idle = 1'b0; end
        5: begin count = 5'd16; scale = 12'($urandom); tx_idle = 1'b0; end
        6: begin count = 5'($urandom_range(2, 16)); scale = 12'd1; end
        default: begin count = 5'($urandom_range(0, 31)); scale = 12'($urandom); end
      endcase
      write_regs(count, scale);
      // long receiver hold while the sender floods the input
      if (p == 5) hold_asks++;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 6 && n == ITEMS_PER_PHASE / 2) wait_idle();
        send_item(random_item());
      end
    end
    wait_idle();

    $display("Coverage: %0d palette writes, %0d pixels (%0d zero), %0d register writes",
             palette_writes, pixels_sent, zero_pixels, reg_writes);
    $display("Compared %0d results; counts 0, 1, 16, 17 and 31, scales 0 to 4095",
             compared_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/odpq_pkg.sv
rtl/odpq_nearest.sv
rtl/ordered_dither_palette_quantizer_unit.sv
rtl/odpq_checker.sv
tb/odpq_result_checker.sv
tb/tb.sv
